[design/swmm_pkg.sv]
`timescale 1ns / 1ps
package swmm_pkg;

  localparam int WINDOW_MAX_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // register file
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int LEN_W      = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

  typedef enum logic [APB_ADDR_W-3:0] {
    REG_WIN_LEN = 1'b0
  } reg_idx_t;

endpackage

[design/swmm_cell.sv]
`timescale 1ns / 1ps
module swmm_cell
  import swmm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    shift,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [SAMPLE_WIDTH-1:0] nb_min,
  input  logic [SAMPLE_WIDTH-1:0] nb_max,
  output logic [SAMPLE_WIDTH-1:0] cur_min,
  output logic [SAMPLE_WIDTH-1:0] cur_max
);

  // cell i holds min/max of the latest i+1 samples: fold the new sample
  // into what the left neighbor held one item ago
  always_ff @(posedge clk) begin
    if (shift) begin
      cur_min <= ($signed(nb_min) < $signed(sample)) ? nb_min : sample;
      cur_max <= ($signed(nb_max) > $signed(sample)) ? nb_max : sample;
    end
  end

endmodule

[design/swmm_select.sv]
`timescale 1ns / 1ps
module swmm_select
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pend,
  input  logic [IDX_W-1:0]                       k_sel,
  input  logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0] cell_min,
  input  logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0] cell_max,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [SAMPLE_WIDTH-1:0]                out_min,
  output logic [SAMPLE_WIDTH-1:0]                out_max
);

  localparam int LO_W = (IDX_W + 1) / 2;
  localparam int GS   = 2 ** LO_W;
  localparam int NG   = (WINDOW_MAX + GS - 1) / GS;
  localparam int HI_W = IDX_W - LO_W;
  localparam int HR_W = (HI_W > 0) ? HI_W : 1;

  logic [NG*GS-1:0][SAMPLE_WIDTH-1:0] pad_min;
  logic [NG*GS-1:0][SAMPLE_WIDTH-1:0] pad_max;
  logic [NG-1:0][SAMPLE_WIDTH-1:0]    pick_min;
  logic [NG-1:0][SAMPLE_WIDTH-1:0]    pick_max;
  logic [NG-1:0][SAMPLE_WIDTH-1:0]    grp_min;
  logic [NG-1:0][SAMPLE_WIDTH-1:0]    grp_max;
  logic [HR_W-1:0]                    khi;
  logic                               gv;
  logic                               out_free;
  logic                               g_adv;
  logic [SAMPLE_WIDTH-1:0]            fin_min;
  logic [SAMPLE_WIDTH-1:0]            fin_max;

  for (genvar i = 0; i < NG * GS; i++) begin : g_pad
    if (i < WINDOW_MAX) begin : g_real
      assign pad_min[i] = cell_min[i];
      assign pad_max[i] = cell_max[i];
    end else begin : g_fill
      assign pad_min[i] = '0;
      assign pad_max[i] = '0;
    end
  end

  // first level: low index bits pick one cell per group
  always_comb begin
    pick_min = '0;
    pick_max = '0;
    for (int g = 0; g < NG; g++) begin
      for (int j = 0; j < GS; j++) begin
        if (k_sel[LO_W-1:0] == LO_W'(j)) begin
          pick_min[g] = pad_min[g*GS+j];
          pick_max[g] = pad_max[g*GS+j];
        end
      end
    end
  end

  // second level: high index bits pick the group
  always_comb begin
    fin_min = '0;
    fin_max = '0;
    for (int g = 0; g < NG; g++) begin
      if (khi == HR_W'(g)) begin
        fin_min = grp_min[g];
        fin_max = grp_max[g];
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign g_adv    = gv && out_free;
  assign take     = !gv || g_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        gv <= pend;
      end
      if (out_free) begin
        out_valid <= gv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grp_min <= pick_min;
      grp_max <= pick_max;
      khi     <= HR_W'(k_sel >> LO_W);
    end
    if (g_adv) begin
      out_min <= fin_min;
      out_max <= fin_max;
    end
  end

endmodule

[design/sliding_window_min_max.sv]
`timescale 1ns / 1ps
// Sliding-window minimum and maximum over a stream of signed samples.
// Input channel s_axis: tdata carries one sample, tlast ends a sequence.
// Output channel m_axis: tdata carries window_min (low) and window_max (high).
// APB register at offset 0 sets the window length, the number of recent
// samples the window spans; write it only while the block is idle. 0 acts
// as 1, values above WINDOW_MAX act as WINDOW_MAX.
// A row of WINDOW_MAX cells keeps, in cell i, the min/max of the latest i+1
// samples; every accepted sample is folded into all cells at once. A scalar
// span register tracks how many of those samples are still live, and a
// two-level registered select picks that cell. Throughput: one item per cycle
// while m_axis does not stall. A result passes the pending flag, the select
// group stage and the output register in turn. Samples before the window has
// filled give no result; the sample marked tlast clears the sequence after its
// own result. While m_axis stalls, up to three results are held (cells, select,
// output register); s_axis_tready drops only once all three are occupied.
// Reset clears the sequence and sets the window length to 1; no clearing pass.
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // stream in
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,  // sample
  input  logic                                     s_axis_tlast,  // last_sample
  // stream out
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // window_min, window_max
  // register port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [APB_ADDR_W-1:0]                    paddr,
  input  logic [APB_DATA_W-1:0]                    pwdata,
  output logic [APB_DATA_W-1:0]                    prdata,
  output logic                                     pready
);

  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int OUT_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

  logic [LEN_W-1:0]                         len_reg;
  logic [31:0]                              len_wide;
  logic [CNT_W-1:0]                         eff_len;
  logic [CNT_W-1:0]                         fill_count;
  logic [CNT_W-1:0]                         fill_inc;
  logic [CNT_W-1:0]                         k_step;
  logic [CNT_W-1:0]                         k_lim;
  logic [IDX_W-1:0]                         k_sel;
  logic [IDX_W-1:0]                         k_sel_next;
  logic                                     produce;
  logic                                     accept;
  logic                                     pv;
  logic                                     take;
  logic [SAMPLE_WIDTH-1:0]                  sample;
  logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0]  cell_min;
  logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0]  cell_max;
  logic [SAMPLE_WIDTH-1:0]                  out_min;
  logic [SAMPLE_WIDTH-1:0]                  out_max;
  reg_idx_t                                 reg_idx;
  logic                                     cfg_wr;

  // ---------------- registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_WIN_LEN: prdata = APB_DATA_W'(len_reg);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LEN_RESET;
    end else if (cfg_wr && reg_idx == REG_WIN_LEN) begin
      len_reg <= pwdata[LEN_W-1:0];
    end
  end

  // ---------------- sequence control ----------------
  assign sample   = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !pv || take;

  assign len_wide = 32'(len_reg);
  assign eff_len  = (len_reg == '0) ? CNT_W'(1) :
                    (len_wide > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(len_wide);

  assign fill_inc = (fill_count < CNT_W'(WINDOW_MAX)) ? fill_count + CNT_W'(1) : fill_count;
  assign produce  = fill_inc >= eff_len;

  // live span grows by one per sample and is cut back by the window length
  assign k_step = CNT_W'(k_sel) + CNT_W'(1);
  assign k_lim  = eff_len - CNT_W'(1);
  assign k_sel_next = (fill_count == '0) ? '0 :
                      IDX_W'((k_step < k_lim) ? k_step : k_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      k_sel      <= '0;
      pv         <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= s_axis_tlast ? '0 : fill_inc;
        k_sel      <= k_sel_next;
        pv         <= produce;
      end else if (take) begin
        pv <= 1'b0;
      end
    end
  end

  // ---------------- cell row ----------------
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk    (clk),
        .shift  (accept),
        .sample (sample),
        .nb_min (sample),
        .nb_max (sample),
        .cur_min(cell_min[i]),
        .cur_max(cell_max[i])
      );
    end else begin : g_body
      swmm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk    (clk),
        .shift  (accept),
        .sample (sample),
        .nb_min (cell_min[i-1]),
        .nb_max (cell_max[i-1]),
        .cur_min(cell_min[i]),
        .cur_max(cell_max[i])
      );
    end
  end

  // ---------------- result select ----------------
  swmm_select #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .pend     (pv),
    .k_sel    (k_sel),
    .cell_min (cell_min),
    .cell_max (cell_max),
    .take     (take),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_min  (out_min),
    .out_max  (out_max)
  );

  assign m_axis_tdata = OUT_W'({out_max, out_min});

  // ---------------- assertions ----------------
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> fill_count == '0)
    else $error("fill count not cleared after last sample");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_MAX))
    else $error("fill count above window capacity");

  a_span_in_fill: assert property (@(posedge clk) disable iff (rst)
    fill_count != '0 |-> CNT_W'(k_sel) < fill_count)
    else $error("live span reaches past the samples of this sequence");

  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    accept && produce |=> pv)
    else $error("result of accepted sample not queued");

endmodule

[verif/tb_sliding_window_min_max.sv]
`timescale 1ns / 1ps
module tb_sliding_window_min_max;
  import swmm_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int WIN_CAP     = WINDOW_MAX_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_WIN_LEN, 2'b00};

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_SET_LEN
  } row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [SW-1:0]   value;     // sample, or window length for ROW_SET_LEN
    logic            lst;
    bit              typed;
    logic [SW-1:0]   want_min;
    logic [SW-1:0]   want_max;
  } stim_row_t;

  typedef struct {
    logic signed [SW-1:0] val;
    int unsigned          age;
  } chain_ent_t;

  typedef struct {
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
  } window_pair_t;

  localparam int N_ROWS = 25;
  localparam logic [SW-1:0] S_MIN = 32'h8000_0000;
  localparam logic [SW-1:0] S_MAX = 32'h7FFF_FFFF;

  // typed expectations only where the window contents are obvious
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_SAMPLE,  S_MIN,        1'b0, 1'b1, S_MIN,        S_MIN},
    '{ROW_SAMPLE,  S_MAX,        1'b0, 1'b1, S_MAX,        S_MAX},
    '{ROW_SAMPLE,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_SET_LEN, 32'd0,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd5,        1'b1, 1'b1, 32'd5,        32'd5},
    '{ROW_SET_LEN, 32'd3,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd10,       1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'hFFFF_FFEC, 1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd7,        1'b0, 1'b1, 32'hFFFF_FFEC, 32'd10},
    '{ROW_SAMPLE,  S_MAX,        1'b0, 1'b1, 32'hFFFF_FFEC, S_MAX},
    '{ROW_SAMPLE,  32'd3,        1'b1, 1'b1, 32'd3,        S_MAX},
    // sequence ends before the window fills
    '{ROW_SAMPLE,  32'd1,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd2,        1'b1, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd4,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd4,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd4,        1'b0, 1'b1, 32'd4,        32'd4},
    '{ROW_SAMPLE,  S_MIN,        1'b0, 1'b1, S_MIN,        32'd4},
    // shrink the window with the sequence still open
    '{ROW_SET_LEN, 32'd2,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd9,        1'b0, 1'b0, '0,           '0},
    // over range, saturates
    '{ROW_SET_LEN, 32'd511,      1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd0,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd6,        1'b1, 1'b0, '0,           '0},
    '{ROW_SET_LEN, 32'd256,      1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'd1,        1'b0, 1'b0, '0,           '0},
    '{ROW_SAMPLE,  32'hFFFF_FFFE, 1'b1, 1'b0, '0,           '0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SW-1:0]          s_axis_tdata = '0;  // sample
  logic                   s_axis_tlast = 1'b0;  // last_sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*SW-1:0]        m_axis_tdata;  // window_min, window_max
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  sliding_window_min_max u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  chain_ent_t       peak_chain[$];
  chain_ent_t       floor_chain[$];
  int unsigned      seq_fill = 0;
  logic [LEN_W-1:0] win_len = LEN_RESET;
  window_pair_t     due_windows[$];

  int          errors = 0;
  int          send_idle_pct = 37;
  int          recv_idle_pct = 71;
  int unsigned stall_cycles = 0;
  int unsigned seq_left = 0;

  function automatic int unsigned span_of(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > WIN_CAP) return WIN_CAP;
    return 32'(v);
  endfunction

  // age entries, expire the oldest, pop dominated entries from the back, push the sample
  function automatic void age_chain(ref chain_ent_t ch[$], input logic signed [SW-1:0] smp,
                                    input int unsigned span, input bit keep_high);
    chain_ent_t ent;
    foreach (ch[i])
      if (ch[i].age < WIN_CAP) ch[i].age++;
    while (ch.size() > 0 && ch[0].age >= span) ch.delete(0);
    while (ch.size() > 0 &&
           (keep_high ? (ch[ch.size()-1].val < smp) : (ch[ch.size()-1].val > smp)))
      ch.delete(ch.size() - 1);
    ent.val = smp;
    ent.age = 0;
    ch.push_back(ent);
  endfunction

  function automatic void track_window(input logic signed [SW-1:0] smp, input logic lst,
                                       output bit made, output window_pair_t res);
    int unsigned span;
    span = span_of(win_len);
    age_chain(peak_chain, smp, span, 1'b1);
    age_chain(floor_chain, smp, span, 1'b0);
    if (seq_fill < WIN_CAP) seq_fill++;
    made = (seq_fill >= span);
    res.lo = floor_chain[0].val;
    res.hi = peak_chain[0].val;
    if (lst) begin
      peak_chain.delete();
      floor_chain.delete();
      seq_fill = 0;
    end
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return S_MIN;
        1: return S_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    // narrow range gives ties
    if (r < 5) return SW'($urandom_range(0, 15)) - SW'(8);
    return $urandom;
  endfunction

  function automatic int unsigned pick_seq_len(input int unsigned span);
    if (span > 32) return $urandom_range(span + 1, span + 20);
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, span);
    return $urandom_range(span, 3 * span + 2);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_sample(input logic [SW-1:0] smp, input logic lst, input bit typed = 1'b0,
                             input logic [SW-1:0] want_min = '0,
                             input logic [SW-1:0] want_max = '0);
    window_pair_t res;
    bit made;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    track_window(smp, lst, made, res);
    if (typed) begin
      made   = 1'b1;
      res.lo = want_min;
      res.hi = want_max;
    end
    if (made) due_windows.push_back(res);
    @(negedge clk);
  endtask

  // waits for the block to go idle, then writes the length and reads it back
  task automatic set_window(input logic [LEN_W-1:0] len_val);
    s_axis_tvalid <= 1'b0;
    while (due_windows.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= APB_DATA_W'(len_val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DATA_W'(len_val)) begin
      errors++;
      $display("%0t length register readback: expected %0d, got %0d", $time, len_val,
               prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    win_len = len_val;
  endtask

  // sequences carry over between calls, so a new length can land mid-sequence
  task automatic run_items(input int n);
    for (int k = 0; k < n; k++) begin
      if (seq_left == 0) seq_left = pick_seq_len(span_of(win_len));
      seq_left--;
      send_sample(pick_sample(), seq_left == 0);
    end
  endtask

  task automatic run_short_windows(input int target);
    int done;
    int n;
    int unsigned r;
    logic [LEN_W-1:0] len_val;
    done = 0;
    while (done < target) begin
      r = $urandom_range(0, 9);
      if (r == 0) len_val = '0;
      else if (r == 1) len_val = 9'd1;
      else if (r == 2) len_val = 9'd2;
      else len_val = LEN_W'($urandom_range(3, 16));
      set_window(len_val);
      n = $urandom_range(20, 60);
      run_items(n);
      done += n;
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    window_pair_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_windows.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, got min %0d max %0d", $time,
                 $signed(m_axis_tdata[SW-1:0]), $signed(m_axis_tdata[2*SW-1:SW]));
      end else begin
        want = due_windows[0];
        due_windows.delete(0);
        if (m_axis_tdata[SW-1:0] !== want.lo || m_axis_tdata[2*SW-1:SW] !== want.hi) begin
          errors++;
          $display("%0t window mismatch: expected min %0d max %0d, got min %0d max %0d",
                   $time, want.lo, want.hi, $signed(m_axis_tdata[SW-1:0]),
                   $signed(m_axis_tdata[2*SW-1:SW]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_sliding_window_min_max NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SET_LEN)
        set_window(directed_rows[i].value[LEN_W-1:0]);
      else
        send_sample(directed_rows[i].value, directed_rows[i].lst, directed_rows[i].typed,
                    directed_rows[i].want_min, directed_rows[i].want_max);
    end

    run_short_windows(150);

    send_idle_pct = 71;
    recv_idle_pct = 37;
    set_window(9'd256);
    run_items(270);
    run_short_windows(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_short_windows(110);

    s_axis_tvalid <= 1'b0;
    while (due_windows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb_sliding_window_min_max OK");
    else
      $display("tb_sliding_window_min_max NOT OK");
    $finish;
  end

endmodule

[files.f]
design/swmm_pkg.sv
design/swmm_cell.sv
design/swmm_select.sv
design/sliding_window_min_max.sv
verif/tb_sliding_window_min_max.sv
